>>> rtl/core/abpf_pkg.sv
// ----------------------------------------------------------------------------
// abpf_pkg
// Shared types and constants of the alpha blend pixel pipeline.
// ----------------------------------------------------------------------------
package abpf_pkg;

  // Conversion selected by the format_mode register
  typedef enum logic [1:0] {
    MODE_RGBA8     = 2'd0,
    MODE_RGB8      = 2'd1,
    MODE_RGB565    = 2'd2,
    MODE_RGBA4_565 = 2'd3
  } mode_t;

  // Configuration register indices
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_ALPHA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE  = 8'd1;

  // floor(x/15) == (x*2185) >> 15 for every x up to 255*15
  localparam logic [11:0] RECIP15       = 12'd2185;
  localparam int unsigned RECIP15_SHIFT = 15;

  localparam int unsigned NCH = 3;

  typedef struct packed {
    logic [7:0] global_alpha;
    mode_t      mode;
  } cfg_t;

  // After stage 1: raw alpha product and per-channel operands
  typedef struct packed {
    mode_t                mode;
    logic [15:0]          aprod;
    logic [NCH-1:0][15:0] s;
    logic [NCH-1:0][15:0] d;
    logic [31:0]          pass;
    logic                 last;
  } s1_t;

  // After stage 2: weights resolved
  typedef struct packed {
    mode_t                mode;
    logic [15:0]          w;
    logic [15:0]          one;
    logic                 zero;
    logic [NCH-1:0][15:0] s;
    logic [NCH-1:0][15:0] d;
    logic [31:0]          pass;
    logic                 last;
  } s2_t;

  // After stage 3: products
  typedef struct packed {
    mode_t                mode;
    logic [NCH-1:0][31:0] pw;
    logic [NCH-1:0][31:0] po;
    logic                 zero;
    logic [31:0]          pass;
    logic                 last;
  } s3_t;

  // Occupancy of a pair of stages and the mode of its later stage
  typedef struct packed {
    logic [1:0] vld;
    mode_t      mode;
  } stat_t;

endpackage

>>> rtl/core/abpf_if.sv
// ----------------------------------------------------------------------------
// abpf_if
// Handshake channels of the blend pipeline: pixels in, pixels out, config.
// ----------------------------------------------------------------------------
interface abpf_pix_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_pixel;
  logic [31:0] dst_pixel;
  logic        last_pixel;

  modport source (output valid, src_pixel, dst_pixel, last_pixel, input ready);
  modport sink   (input valid, src_pixel, dst_pixel, last_pixel, output ready);
endinterface

interface abpf_pix_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        written;
  logic        last_out;

  modport source (output valid, out_pixel, written, last_out, input ready);
  modport sink   (input valid, out_pixel, written, last_out, output ready);
endinterface

interface abpf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/abpf_cfg.sv
// ----------------------------------------------------------------------------
// abpf_cfg
// Configuration registers: global alpha and format mode.
// ----------------------------------------------------------------------------
module abpf_cfg
  import abpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  abpf_cfg_if.sink         cfg,
  output cfg_t             cfg_q
);

  logic [7:0] global_alpha;
  mode_t      mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      global_alpha <= 8'd255;
      mode         <= MODE_RGBA8;
    end else if (cfg.valid && cfg.ready) begin
      // writes to unknown indices are dropped
      if (cfg.index == REG_GLOBAL_ALPHA) begin
        global_alpha <= cfg.data;
      end else if (cfg.index == REG_FORMAT_MODE) begin
        mode <= mode_t'(cfg.data[1:0]);
      end
    end
  end

  assign cfg_q.global_alpha = global_alpha;
  assign cfg_q.mode         = mode;

endmodule

>>> rtl/core/abpf_front.sv
// ----------------------------------------------------------------------------
// abpf_front
// Stages 1 and 2: unpack operands, alpha product, blend weights.
// ----------------------------------------------------------------------------
module abpf_front
  import abpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg_q,
  abpf_pix_in_if.sink pix_in,
  output s2_t        s2,
  output logic       s2_valid,
  input  logic       s2_ready,
  output stat_t      stat
);

  s1_t  s1, s1_next;
  s2_t  s2_next;
  logic v1, v2;
  logic load1, load2;
  logic [7:0]  a_op;
  logic [23:0] q15;
  logic [31:0] src, dst;

  assign load2 = !v2 || s2_ready;
  assign load1 = !v1 || load2;
  assign pix_in.ready = load1;

  assign src = pix_in.src_pixel;
  assign dst = pix_in.dst_pixel;

  // stage 1: operand unpack per format
  always_comb begin
    s1_next.mode = cfg_q.mode;
    s1_next.last = pix_in.last_pixel;
    a_op = (cfg_q.mode == MODE_RGBA4_565) ? {4'd0, src[3:0]} : src[31:24];
    s1_next.aprod = 16'(cfg_q.global_alpha) * 16'(a_op);
    s1_next.s = '0;
    s1_next.d = '0;
    s1_next.pass = '0;
    case (cfg_q.mode)
      MODE_RGBA8, MODE_RGB8: begin
        for (int c = 0; c < NCH; c++) begin
          s1_next.s[c] = {8'd0, src[8*c +: 8]};
          s1_next.d[c] = {8'd0, dst[8*c +: 8]};
        end
        s1_next.pass = (cfg_q.mode == MODE_RGBA8) ? dst : {8'd0, dst[23:0]};
      end
      MODE_RGB565: begin
        // source blue lands in the top field
        s1_next.s[2] = {8'd0, src[23:16]};
        s1_next.d[2] = {8'd0, dst[15:11], 3'd0};
        s1_next.s[1] = {8'd0, src[15:8]};
        s1_next.d[1] = {8'd0, dst[10:5], 2'd0};
        s1_next.s[0] = {8'd0, src[7:0]};
        s1_next.d[0] = {8'd0, dst[4:0], 3'd0};
        s1_next.pass = {16'd0, dst[15:0]};
      end
      MODE_RGBA4_565: begin
        // 4-bit fields widened with a half-LSB bit, kept at 565 alignment
        s1_next.s[2] = {src[15:12], 1'b1, 11'd0};
        s1_next.d[2] = {dst[15:11], 11'd0};
        s1_next.s[1] = {5'd0, src[11:8], 1'b1, 6'd0};
        s1_next.d[1] = {5'd0, dst[10:5], 5'd0};
        s1_next.s[0] = {11'd0, src[7:4], 1'b1};
        s1_next.d[0] = {11'd0, dst[4:0]};
        s1_next.pass = {16'd0, dst[15:0]};
      end
      default: begin
        s1_next.pass = dst;
      end
    endcase
  end

  // stage 2: weights
  assign q15 = 24'(s1.aprod[11:0]) * 24'(RECIP15);

  always_comb begin
    s2_next.mode = s1.mode;
    s2_next.s    = s1.s;
    s2_next.d    = s1.d;
    s2_next.pass = s1.pass;
    s2_next.last = s1.last;
    case (s1.mode)
      MODE_RGBA8, MODE_RGB8: s2_next.w = s1.aprod;
      MODE_RGB565:           s2_next.w = {8'd0, s1.aprod[15:8]};
      MODE_RGBA4_565:        s2_next.w = {8'd0, q15[RECIP15_SHIFT +: 8]};
      default:               s2_next.w = s1.aprod;
    endcase
    s2_next.one  = (s1.mode == MODE_RGBA8 || s1.mode == MODE_RGB8) ?
                   16'hFFFF - s2_next.w : 16'd255 - s2_next.w;
    s2_next.zero = (s2_next.w == 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (load1) v1 <= pix_in.valid;
      if (load2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && pix_in.valid) s1 <= s1_next;
    if (load2 && v1)           s2 <= s2_next;
  end

  assign s2_valid  = v2;
  assign stat.vld  = {v2, v1};
  assign stat.mode = s2.mode;

endmodule

>>> rtl/core/abpf_mix.sv
// ----------------------------------------------------------------------------
// abpf_mix
// Stages 3 and 4: channel products, then sum, field extract and pack.
// ----------------------------------------------------------------------------
module abpf_mix
  import abpf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  s2_t           s2,
  input  logic          s2_valid,
  output logic          s2_ready,
  abpf_pix_out_if.source pix_out,
  output stat_t         stat
);

  s3_t  s3, s3_next;
  logic v3, v4;
  logic load3, load4;
  logic [NCH-1:0][31:0] sum;
  logic [31:0] res;
  logic [31:0] out_pixel;
  logic        written;
  logic        last_out;
  mode_t       out_mode;

  assign load4 = !v4 || pix_out.ready;
  assign load3 = !v3 || load4;
  assign s2_ready = load3;

  // stage 3: one pair of multipliers per channel
  always_comb begin
    s3_next.mode = s2.mode;
    s3_next.zero = s2.zero;
    s3_next.pass = s2.pass;
    s3_next.last = s2.last;
    for (int c = 0; c < NCH; c++) begin
      s3_next.pw[c] = 32'(s2.w)   * 32'(s2.s[c]);
      s3_next.po[c] = 32'(s2.one) * 32'(s2.d[c]);
    end
  end

  // stage 4: sum and pack
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum[c] = s3.pw[c] + s3.po[c];
    end
    case (s3.mode)
      MODE_RGBA8:     res = {8'hFF, sum[2][23:16], sum[1][23:16], sum[0][23:16]};
      MODE_RGB8:      res = {8'h00, sum[2][23:16], sum[1][23:16], sum[0][23:16]};
      MODE_RGB565:    res = {16'd0, sum[2][15:11], sum[1][15:10], sum[0][15:11]};
      MODE_RGBA4_565: res = {16'd0, sum[2][23:19], sum[1][18:13], sum[0][12:8]};
      default:        res = s3.pass;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (load3) v3 <= s2_valid;
      if (load4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (load3 && s2_valid) s3 <= s3_next;
    if (load4 && v3) begin
      out_pixel <= s3.zero ? s3.pass : res;
      written   <= !s3.zero;
      last_out  <= s3.last;
      out_mode  <= s3.mode;
    end
  end

  assign pix_out.valid     = v4;
  assign pix_out.out_pixel = out_pixel;
  assign pix_out.written   = written;
  assign pix_out.last_out  = last_out;
  assign stat.vld          = {v4, v3};
  assign stat.mode         = out_mode;

endmodule

>>> rtl/core/alpha_blend_pixel_formats.sv
// ----------------------------------------------------------------------------
// alpha_blend_pixel_formats
// Source-over blend of one pixel onto another with a global alpha.
// ----------------------------------------------------------------------------
// Four-stage pipeline taking one pixel request per clock while the output
// side is not stalled, and returning one result per request, in order.
// Stage 1 unpacks the source and destination fields for the selected format
// and forms global_alpha * source alpha; stage 2 turns that into the weight
// pair (w, full-w), the /15 of the RGBA4 mode done as a reciprocal multiply;
// stage 3 holds two multipliers per colour channel; stage 4 adds, extracts
// the fields and packs them into the output register.
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up and input ready only drops once all four stages are full
// and the output is stalled. A zero weight passes the destination through
// with written clear. Configuration writes take effect on the next pixel
// accepted and must only be made while the pipeline is empty.
// ----------------------------------------------------------------------------
module alpha_blend_pixel_formats
  import abpf_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  abpf_cfg_if.sink       cfg,
  abpf_pix_in_if.sink    pix_in,
  abpf_pix_out_if.source pix_out
);

  cfg_t  cfg_q;
  s2_t   s2;
  logic  s2_valid;
  logic  s2_ready;
  stat_t front_stat;
  stat_t mix_stat;

  // register file
  abpf_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  // unpack and weight stages
  abpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_q    (cfg_q),
    .pix_in   (pix_in),
    .s2       (s2),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .stat     (front_stat)
  );

  // multiply and pack stages
  abpf_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .s2       (s2),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .pix_out  (pix_out),
    .stat     (mix_stat)
  );

  // back-pressure at the input only with every stage occupied
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (&front_stat.vld && &mix_stat.vld))
    else $error("input stalled with a bubble in the pipeline");

  // a blended RGBA8 pixel carries an opaque alpha byte
  a_rgba8_alpha: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && pix_out.written && mix_stat.mode == MODE_RGBA8)
      |-> pix_out.out_pixel[31:24] == 8'hFF)
    else $error("RGBA8 blend without opaque alpha");

  // 565 results never set the upper half
  a_565_upper: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && (mix_stat.mode == MODE_RGB565 || mix_stat.mode == MODE_RGBA4_565))
      |-> pix_out.out_pixel[31:16] == 16'd0)
    else $error("565 result with upper bits set");

  // RGB8 results never set the top byte
  a_rgb8_upper: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && mix_stat.mode == MODE_RGB8) |-> pix_out.out_pixel[31:24] == 8'd0)
    else $error("RGB8 result with top byte set");

endmodule

>>> tb/alpha_blend_pixel_formats_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_blend_pixel_formats_test
// Self-checking bench for the four-format source-over pixel blender.
// ----------------------------------------------------------------------------
// Pixel requests go in over a valid/ready channel in bursts with random gaps,
// while the output side stalls on its own changing pattern. Every accepted
// request is run through a behavioural predictor of the blend, and returned
// pixels are compared field by field, in order, with the predictions. The
// run steps through all four formats and a spread of global alpha values,
// zero and full scale included, rewriting the registers only once the
// pipeline has drained.
// ----------------------------------------------------------------------------
module alpha_blend_pixel_formats_test;
  import abpf_pkg::*;

  localparam int unsigned CLK_HALF     = 4;     // 8 ns period
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned PIPE_DEPTH   = 4;     // stage count of the block
  localparam int unsigned TAIL_CYCLES  = 3 * PIPE_DEPTH;
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no request moving
  localparam int unsigned RAND_PHASES  = 12;
  localparam int unsigned RAND_ITEMS   = 450;
  localparam int unsigned REPORT_MAX   = 10;

  // Indices outside the register map; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_STRAY_LOW  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRAY_HIGH = 8'hFF;

  // One returned pixel as the output channel carries it
  typedef struct packed {
    logic [31:0] pix;
    logic        written;
    logic        last;
  } blend_px_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the two registers, predicts each
  // accepted request and checks results against the oldest prediction.
  // --------------------------------------------------------------------------
  class blend_scoreboard;
    logic [7:0]  alpha;
    mode_t       mode;
    blend_px_t   expected_q[$];
    int unsigned mismatches;
    int unsigned blends;
    int unsigned passes;
    int unsigned rows;
    int unsigned mode_hits[4];

    function new();
      alpha      = 8'd255;
      mode       = MODE_RGBA8;
      mismatches = 0;
      blends     = 0;
      passes     = 0;
      rows       = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == REG_GLOBAL_ALPHA)
        alpha = val;
      else if (idx == REG_FORMAT_MODE)
        mode = mode_t'(val[1:0]);
    endfunction

    // 16-bit weighted mix of one 8-bit channel
    function logic [7:0] mix_channel(logic [31:0] w, logic [7:0] s, logic [7:0] d);
      logic [31:0] sum;
      sum = w * 32'(s) + (32'd65535 - w) * 32'(d);
      return sum[23:16];
    endfunction

    function blend_px_t blend_pixel(logic [31:0] s, logic [31:0] d, logic l);
      blend_px_t   r;
      logic [31:0] w;
      logic [31:0] inv;
      logic [31:0] sr;
      logic [31:0] sg;
      logic [31:0] sb;
      r.last    = l;
      r.written = 1'b0;
      case (mode)
        MODE_RGBA8, MODE_RGB8: begin
          w     = 32'(alpha) * 32'(s[31:24]);
          r.pix = (mode == MODE_RGBA8) ? d : {8'h00, d[23:0]};
          if (w != 0) begin
            r.pix = {(mode == MODE_RGBA8) ? 8'hFF : 8'h00,
                     mix_channel(w, s[23:16], d[23:16]),
                     mix_channel(w, s[15:8],  d[15:8]),
                     mix_channel(w, s[7:0],   d[7:0])};
            r.written = 1'b1;
          end
        end
        MODE_RGB565: begin
          w     = (32'(alpha) * 32'(s[31:24])) >> 8;
          inv   = 32'd255 - w;
          r.pix = {16'h0000, d[15:0]};
          if (w != 0) begin
            // source blue lands in the top field, red in the bottom one
            sr    = 32'(s[23:16]) * w + 32'({d[15:11], 3'b000}) * inv;
            sg    = 32'(s[15:8])  * w + 32'({d[10:5], 2'b00})   * inv;
            sb    = 32'(s[7:0])   * w + 32'({d[4:0], 3'b000})   * inv;
            r.pix = {16'h0000, sr[15:11], sg[15:10], sb[15:11]};
            r.written = 1'b1;
          end
        end
        default: begin
          w     = (32'(alpha) * 32'(s[3:0])) / 32'd15;
          inv   = 32'd255 - w;
          r.pix = {16'h0000, d[15:0]};
          if (w != 0) begin
            // 4-bit fields widened with a half-LSB bit, mixed at 565 alignment
            sr    = 32'({s[15:12], 1'b1, 11'h000}) * w + 32'({d[15:11], 11'h000}) * inv;
            sg    = 32'({s[11:8], 1'b1, 6'h00})    * w + 32'({d[10:5], 5'h00})    * inv;
            sb    = 32'({s[7:4], 1'b1})            * w + 32'(d[4:0])              * inv;
            r.pix = {16'h0000, sr[23:19], sg[18:13], sb[12:8]};
            r.written = 1'b1;
          end
        end
      endcase
      return r;
    endfunction

    function void note_request(logic [31:0] s, logic [31:0] d, logic l);
      blend_px_t e;
      e = blend_pixel(s, d, l);
      expected_q.push_back(e);
      mode_hits[mode]++;
      if (e.written) blends++; else passes++;
      if (l) rows++;
    endfunction

    function void check_result(logic [31:0] pix, logic wr, logic l);
      blend_px_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected pixel %h written=%b last=%b", $realtime, pix, wr, l);
        return;
      end
      e = expected_q.pop_front();
      if (pix !== e.pix || wr !== e.written || l !== e.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: mismatch exp pix=%h wr=%b last=%b got pix=%h wr=%b last=%b",
                   $realtime, e.pix, e.written, e.last, pix, wr, l);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  abpf_cfg_if     cfg();
  abpf_pix_in_if  pix_in();
  abpf_pix_out_if pix_out();

  alpha_blend_pixel_formats u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  blend_scoreboard sb = new();

  int unsigned settings;     // register writes made
  int unsigned idle_cycles;  // watchdog count

  // Receiver stall pattern state
  int unsigned stall_style;
  int unsigned style_left;
  int unsigned run_left;
  logic        run_ready;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // --------------------------------------------------------------------------
  // Receiver: switches between always ready, independent random stalls and long
  // on/off runs, so stalls land on every pipeline phase.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
      stall_style = 0;
      style_left  = 0;
      run_left    = 0;
      run_ready   = 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(2, 0);
        style_left  = $urandom_range(120, 20);
      end
      style_left--;
      case (stall_style)
        0: pix_out.ready <= 1'b1;
        1: pix_out.ready <= ($urandom_range(3, 0) != 0);
        default: begin
          if (run_left == 0) begin
            run_ready = !run_ready;
            run_left  = run_ready ? $urandom_range(12, 1) : $urandom_range(12, 1);
          end
          run_left--;
          pix_out.ready <= run_ready;
        end
      endcase
    end
  end

  // Output monitor: values sampled here are the pre-edge ones
  always @(posedge clk) begin
    if (!rst && pix_out.valid === 1'b1 && pix_out.ready === 1'b1)
      sb.check_result(pix_out.out_pixel, pix_out.written, pix_out.last_out);
  end

  // Watchdog: any request moving on any channel resets the count
  always @(posedge clk) begin
    if (rst ||
        (pix_in.valid && pix_in.ready) ||
        (pix_out.valid && pix_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. All start and end just after a rising edge.
  // --------------------------------------------------------------------------

  // Holds valid high; the caller lowers it when a gap follows
  task automatic send_pixel(input logic [31:0] s, input logic [31:0] d, input logic l);
    pix_in.valid      <= 1'b1;
    pix_in.src_pixel  <= s;
    pix_in.dst_pixel  <= d;
    pix_in.last_pixel <= l;
    do @(posedge clk); while (pix_in.ready !== 1'b1);
    sb.note_request(s, d, l);
  endtask

  // Sender pause until every predicted pixel has come back, plus a margin
  task automatic drain_pipe();
    pix_in.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Only called with the pipeline empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    sb.set_reg(idx, val);
    settings++;
    @(posedge clk);
  endtask

  // Random source with the alpha byte and the RGBA4 alpha nibble pushed
  // towards their extremes a fair share of the time
  function automatic logic [31:0] rand_src();
    logic [31:0] s;
    s = $urandom;
    case ($urandom_range(7, 0))
      0: s[31:24] = 8'h00;
      1: s[31:24] = 8'hFF;
      2: s[3:0]   = 4'h0;
      3: s[3:0]   = 4'hF;
      4: s[31:24] = 8'h01;
      default: ;
    endcase
    return s;
  endfunction

  // Directed: field extremes, weight-zero pass-through in every format,
  // junk in the unused upper bits, tiny weights and dropped stray writes
  task automatic run_directed();
    // reset values: global alpha full scale, RGBA8 onto RGBA8
    send_pixel(32'hFFFFFFFF, 32'h00000000, 1'b0);
    send_pixel(32'h00FFFFFF, 32'hFFFFFFFF, 1'b0);   // alpha zero
    send_pixel(32'h80FF0080, 32'h12345678, 1'b1);
    drain_pipe();

    write_reg(REG_FORMAT_MODE, 8'(MODE_RGB8));
    send_pixel(32'hFFFFFFFF, 32'hFF000000, 1'b0);
    send_pixel(32'h00123456, 32'hAB654321, 1'b0);   // pass, top byte dropped
    send_pixel(32'h7F00FF00, 32'hFFFFFFFF, 1'b1);
    drain_pipe();

    write_reg(REG_FORMAT_MODE, 8'(MODE_RGB565));
    send_pixel(32'hFFFFFFFF, 32'hFFFF0000, 1'b0);
    send_pixel(32'h01FFFFFF, 32'h0000FFFF, 1'b0);   // weight rounds to zero
    send_pixel(32'hFF0000FF, 32'hFFFFFFFF, 1'b1);
    send_pixel(32'h80808080, 32'hABCD1234, 1'b0);
    drain_pipe();

    write_reg(REG_GLOBAL_ALPHA, 8'd1);
    send_pixel(32'hFF123456, 32'h0000BEEF, 1'b0);   // (1*255)>>8 is zero
    drain_pipe();

    write_reg(REG_FORMAT_MODE, 8'(MODE_RGBA4_565));
    send_pixel(32'hFFFF000F, 32'hFFFF1234, 1'b0);   // smallest non-zero weight
    send_pixel(32'h0000FFFE, 32'h00005555, 1'b1);   // 14/15 truncates to zero
    drain_pipe();

    write_reg(REG_GLOBAL_ALPHA, 8'd255);
    send_pixel(32'hFFFF0000, 32'hFFFFFFFF, 1'b0);   // a4 zero
    send_pixel(32'hFFFFFFFF, 32'h00000000, 1'b0);
    send_pixel(32'h0000000F, 32'hFFFFFFFF, 1'b1);
    send_pixel(32'hABCD1238, 32'h12345678, 1'b0);
    drain_pipe();

    write_reg(REG_STRAY_LOW, 8'hFF);
    write_reg(REG_STRAY_HIGH, 8'h00);
    write_reg(REG_GLOBAL_ALPHA, 8'd0);
    write_reg(REG_FORMAT_MODE, 8'(MODE_RGBA8));
    send_pixel(32'hFFFFFFFF, 32'h5A5AA5A5, 1'b1);   // global alpha zero
    drain_pipe();
  endtask

  // One random phase: rows of random length marked by last_pixel, sent in
  // bursts; some phases never idle the sender
  task automatic run_phase(input int unsigned p, input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned gap_max;
    int unsigned row_left;
    logic [31:0] s;
    logic [31:0] d;
    logic        l;
    sent     = 0;
    gap_max  = (p % 3 == 1) ? 0 : 8;
    row_left = $urandom_range(32, 1);
    while (sent < n_items) begin
      burst = $urandom_range(16, 1);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        s = rand_src();
        d = $urandom;
        // mostly well-formed rows, with the odd stray row mark
        l = (row_left == 1) || ($urandom_range(19, 0) == 0);
        row_left--;
        if (row_left == 0) row_left = $urandom_range(32, 1);
        send_pixel(s, d, l);
        sent++;
      end
      gap = $urandom_range(gap_max, 0);
      if (gap != 0 && sent < n_items) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    drain_pipe();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] ga;
    settings           = 0;
    rst               <= 1'b1;
    cfg.valid         <= 1'b0;
    cfg.index         <= '0;
    cfg.data          <= '0;
    pix_in.valid      <= 1'b0;
    pix_in.src_pixel  <= '0;
    pix_in.dst_pixel  <= '0;
    pix_in.last_pixel <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // Each phase rewrites both registers with the pipeline drained; the
    // drain at the end of every phase is also the sender's full pause
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0, 7:    ga = 8'd255;
        5:       ga = 8'd0;
        6:       ga = 8'd1;
        10:      ga = 8'd128;
        default: ga = 8'($urandom_range(255, 0));
      endcase
      write_reg(REG_GLOBAL_ALPHA, ga);
      write_reg(REG_FORMAT_MODE, 8'(mode_t'(p % 4)));
      if (p % 3 == 2)
        write_reg(8'($urandom_range(255, 2)), 8'($urandom));
      run_phase(p, RAND_ITEMS / RAND_PHASES);
    end

    $display("Checked %0d blended and %0d passed-through pixels, %0d row ends",
             sb.blends, sb.passes, sb.rows);
    $display("Requests per format 0..3: %0d %0d %0d %0d; register writes: %0d",
             sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2], sb.mode_hits[3],
             settings);
    if (sb.pending() != 0)
      $display("%0d predicted pixels never returned", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
